>>> design/tepq_pkg.sv
// Shared types and constants for the timer event priority queue.
package tepq_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic
    {
        OP_SCHEDULE = 1'b0,
        OP_DRAIN    = 1'b1
    } op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed
    {
        logic [31:0] wakeup;
        logic [31:0] order;
        logic [31:0] subject;
        logic [31:0] target;
        logic [2:0]  kind;
        logic [15:0] zone;
    } slot_entry_t;

    typedef struct packed
    {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

>>> design/tepq_slot_ram.sv
// Slot store: one write port and one registered read port.
module tepq_slot_ram #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  tepq_pkg::slot_entry_t wdata,
    input  logic [IDX_W-1:0]     raddr,
    output tepq_pkg::slot_entry_t rdata
);
    import tepq_pkg::*;

    slot_entry_t mem_reg [DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tepq_scan_unit.sv
// Shared compare unit that tracks the earliest live slot and the first free slot.
module tepq_scan_unit #(
    parameter int IDX_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tepq_pkg::scan_ctl_t   ctl,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic                  slot_live,
    input  tepq_pkg::slot_entry_t rd_data,
    output logic                  found,
    output logic [IDX_W-1:0]      best_idx,
    output tepq_pkg::slot_entry_t best,
    output logic                  free_found,
    output logic [IDX_W-1:0]      free_idx
);
    import tepq_pkg::*;

    logic        found_reg, found_next;
    logic        free_found_reg, free_found_next;
    logic [IDX_W-1:0] best_idx_reg, free_idx_reg;
    slot_entry_t best_reg;
    logic        better;
    logic        take_best;
    logic        take_free;

    // Strictly earlier by wakeup then sequence, so ties keep the lower index.
    assign better = !found_reg
                    || (rd_data.wakeup < best_reg.wakeup)
                    || ((rd_data.wakeup == best_reg.wakeup)
                        && (rd_data.order < best_reg.order));

    assign take_best = ctl.sample && slot_live && better;
    assign take_free = ctl.sample && !slot_live && !free_found_reg;

    always_comb
    begin
        found_next      = found_reg;
        free_found_next = free_found_reg;
        if (ctl.clear)
        begin
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else
        begin
            if (take_best)
            begin
                found_next = 1'b1;
            end
            if (take_free)
            begin
                free_found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && take_best)
        begin
            best_reg     <= rd_data;
            best_idx_reg <= rd_idx;
        end
        if (!ctl.clear && take_free)
        begin
            free_idx_reg <= rd_idx;
        end
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best       = best_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;

endmodule

>>> design/timer_event_priority_queue.sv
// Top level of the timer event priority queue: sequencer, slot flags and result register.
//
// Holds up to CAPACITY pending timer events in a slot memory with one read port,
// scanned one slot a cycle by a single wakeup/sequence comparator. A schedule
// transaction makes one pass over the slots, then decides and writes, then
// presents its result. A drain transaction that removes n events makes n + 1
// passes over the slots and offers each result in turn, waiting while
// rsp_stall is high. The block takes no new request until the last result of
// the current one has been accepted. No clearing pass is needed after reset.
module timer_event_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        mode,
    input  logic [31:0] now_time,
    input  logic [23:0] delay,
    input  logic [31:0] subject_id,
    input  logic [31:0] target_id,
    input  logic [2:0]  event_kind,
    input  logic [15:0] zone_id,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        has_event,
    output logic [31:0] out_subject,
    output logic [31:0] out_target,
    output logic [2:0]  out_kind,
    output logic [15:0] out_zone,
    output logic [31:0] out_wakeup,
    output logic        last,
    output logic        became_earliest,
    output logic        dropped_full
);
    import tepq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0]     SCAN_END  = CNT_W'(CAPACITY);
    localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(MAX_RESULTS);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [CAPACITY-1:0] slot_valid_reg, slot_valid_next;
    logic [31:0]         next_order_reg, next_order_next;
    logic                pend_reg, pend_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                last_reg, last_next;

    op_t                 op_reg;
    logic [31:0]         now_reg;
    logic [31:0]         wake_reg;
    logic [31:0]         subject_reg;
    logic [31:0]         target_reg;
    logic [2:0]          kind_reg;
    logic [15:0]         zone_reg;
    slot_entry_t         pend_entry_reg;

    logic                has_event_reg;
    slot_entry_t         out_entry_reg;
    logic                early_reg;
    logic                drop_reg;

    logic                req_fire;
    logic                rsp_fire;
    logic [32:0]         wake_sum;
    logic [31:0]         wake_sat;
    scan_ctl_t           scan_ctl;
    logic                scan_start;
    logic                slot_live;
    slot_entry_t         rd_data;
    slot_entry_t         wr_data;
    logic                wr_en;
    logic                best_found;
    logic [IDX_W-1:0]    best_idx;
    slot_entry_t         best_entry;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                due_ok;
    logic                load_out;
    logic                out_has;
    slot_entry_t         out_src;
    logic                out_early;
    logic                out_drop;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && (state_reg == ST_IDLE);
    assign rsp_fire  = rsp_valid_reg && !rsp_stall;

    assign wake_sum = {1'b0, now_time} + {9'b0, delay};
    assign wake_sat = wake_sum[32] ? TIME_MAX : wake_sum[31:0];

    assign slot_live = slot_valid_reg[rd_idx_reg];

    assign wr_data.wakeup  = wake_reg;
    assign wr_data.order   = next_order_reg;
    assign wr_data.subject = subject_reg;
    assign wr_data.target  = target_reg;
    assign wr_data.kind    = kind_reg;
    assign wr_data.zone    = zone_reg;
    assign wr_en = (state_reg == ST_EVAL) && (op_reg == OP_SCHEDULE) && free_found;

    assign due_ok = best_found && (best_entry.wakeup <= now_reg) && (res_cnt_reg < RES_LIMIT);

    assign scan_ctl.clear  = scan_start;
    assign scan_ctl.sample = rd_pend_reg;

    tepq_slot_ram #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (free_idx),
        .wdata (wr_data),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    tepq_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .rd_idx     (rd_idx_reg),
        .slot_live  (slot_live),
        .rd_data    (rd_data),
        .found      (best_found),
        .best_idx   (best_idx),
        .best       (best_entry),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        slot_valid_next = slot_valid_reg;
        next_order_next = next_order_reg;
        pend_next       = pend_reg;
        res_cnt_next    = res_cnt_reg;
        rsp_valid_next  = rsp_valid_reg;
        last_next       = last_reg;
        scan_start      = 1'b0;
        load_out        = 1'b0;
        out_has         = 1'b0;
        out_src         = pend_entry_reg;
        out_early       = 1'b0;
        out_drop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    scan_start   = 1'b1;
                    cnt_next     = '0;
                    pend_next    = 1'b0;
                    res_cnt_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Read data is registered behind the address, so the pass ends in the
                // cycle after the last slot has been addressed.
                if (cnt_reg == SCAN_END)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_SCHEDULE)
                begin
                    load_out  = 1'b1;
                    last_next = 1'b1;
                    if (free_found)
                    begin
                        slot_valid_next[free_idx] = 1'b1;
                        next_order_next = next_order_reg + 1'b1;
                        out_early = !best_found || (wake_reg < best_entry.wakeup);
                    end
                    else
                    begin
                        out_drop = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    // The event taken on the previous pass is held back until
                    // this pass shows whether another one follows it.
                    if (due_ok)
                    begin
                        slot_valid_next[best_idx] = 1'b0;
                        pend_next    = 1'b1;
                        res_cnt_next = res_cnt_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        load_out   = 1'b1;
                        out_has    = 1'b1;
                        last_next  = !due_ok;
                        state_next = ST_EMIT;
                    end
                    else if (due_ok)
                    begin
                        scan_start = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        load_out   = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
                if (load_out)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (rsp_fire)
                begin
                    rsp_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            slot_valid_reg <= '0;
            next_order_reg <= '0;
            pend_reg       <= 1'b0;
            res_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            slot_valid_reg <= slot_valid_next;
            next_order_reg <= next_order_next;
            pend_reg       <= pend_next;
            res_cnt_reg    <= res_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        if (req_fire)
        begin
            op_reg      <= op_t'(mode);
            now_reg     <= now_time;
            wake_reg    <= wake_sat;
            subject_reg <= subject_id;
            target_reg  <= target_id;
            kind_reg    <= event_kind;
            zone_reg    <= zone_id;
        end
        if ((state_reg == ST_EVAL) && (op_reg == OP_DRAIN) && due_ok)
        begin
            pend_entry_reg <= best_entry;
        end
        if (load_out)
        begin
            has_event_reg <= out_has;
            out_entry_reg <= out_has ? out_src : '0;
            early_reg     <= out_early;
            drop_reg      <= out_drop;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign has_event       = has_event_reg;
    assign out_subject     = out_entry_reg.subject;
    assign out_target      = out_entry_reg.target;
    assign out_kind        = out_entry_reg.kind;
    assign out_zone        = out_entry_reg.zone;
    assign out_wakeup      = out_entry_reg.wakeup;
    assign last            = last_reg;
    assign became_earliest = early_reg;
    assign dropped_full    = drop_reg;

endmodule

>>> test/timer_event_priority_queue_tb.sv
// Self-checking testbench for the timer event priority queue.
module timer_event_priority_queue_tb;

    import tepq_pkg::*;

    localparam int CAPACITY = 32;
    localparam int ITEM_TARGET = 270;

    typedef struct packed
    {
        logic        has_event;
        logic [31:0] subject;
        logic [31:0] target;
        logic [2:0]  kind;
        logic [15:0] zone;
        logic [31:0] wakeup;
        logic        last;
        logic        became_earliest;
        logic        dropped_full;
    } event_result_t;

    // Mirror of the pending event store, with the results still owed by the block.
    class event_queue_scoreboard;
        bit          slot_used [CAPACITY];
        bit [31:0]   slot_wake [CAPACITY];
        bit [31:0]   slot_seq [CAPACITY];
        bit [31:0]   slot_subj [CAPACITY];
        bit [31:0]   slot_tgt [CAPACITY];
        bit [2:0]    slot_kind [CAPACITY];
        bit [15:0]   slot_zone [CAPACITY];
        bit [31:0]   seq_count;
        event_result_t owed [$];
        int          failures;

        function int earliest_slot();
            int best;
            best = -1;
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_used[i] && (best < 0 || slot_wake[i] < slot_wake[best] ||
                    (slot_wake[i] == slot_wake[best] && slot_seq[i] < slot_seq[best])))
                    best = i;
            end
            return best;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            for (int i = 0; i < CAPACITY; i++)
                n += int'(slot_used[i]);
            return n;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_request(op_t op, bit [31:0] now, bit [23:0] dly, bit [31:0] subj,
                                   bit [31:0] tgt, bit [2:0] kind, bit [15:0] zone);
            event_result_t r;
            bit [32:0]     sum;
            bit [31:0]     wake;
            int            free_slot;
            int            top;
            int            n;
            if (op == OP_SCHEDULE)
            begin
                sum = {1'b0, now} + {9'd0, dly};
                wake = sum[32] ? TIME_MAX : sum[31:0];
                free_slot = -1;
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!slot_used[i])
                        free_slot = i;
                r = '0;
                r.last = 1'b1;
                if (free_slot < 0)
                    r.dropped_full = 1'b1;
                else
                begin
                    top = earliest_slot();
                    r.became_earliest = (top < 0) || (wake < slot_wake[top]);
                    slot_used[free_slot] = 1'b1;
                    slot_wake[free_slot] = wake;
                    slot_seq[free_slot]  = seq_count;
                    slot_subj[free_slot] = subj;
                    slot_tgt[free_slot]  = tgt;
                    slot_kind[free_slot] = kind;
                    slot_zone[free_slot] = zone;
                    seq_count = seq_count + 1;
                end
                owed = {owed, r};
            end
            else
            begin
                n = 0;
                top = earliest_slot();
                while (n < MAX_RESULTS && top >= 0 && slot_wake[top] <= now)
                begin
                    r = '0;
                    r.has_event = 1'b1;
                    r.subject = slot_subj[top];
                    r.target  = slot_tgt[top];
                    r.kind    = slot_kind[top];
                    r.zone    = slot_zone[top];
                    r.wakeup  = slot_wake[top];
                    slot_used[top] = 1'b0;
                    n++;
                    top = earliest_slot();
                    r.last = (n == MAX_RESULTS) || (top < 0) || (slot_wake[top] > now);
                    owed = {owed, r};
                end
                if (n == 0)
                begin
                    r = '0;
                    r.last = 1'b1;
                    owed = {owed, r};
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(event_result_t got);
            event_result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, expected none, actual %h",
                         $time, got);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("has_event", 32'(want.has_event), 32'(got.has_event));
            compare_field("out_subject", want.subject, got.subject);
            compare_field("out_target", want.target, got.target);
            compare_field("out_kind", 32'(want.kind), 32'(got.kind));
            compare_field("out_zone", 32'(want.zone), 32'(got.zone));
            compare_field("out_wakeup", want.wakeup, got.wakeup);
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("became_earliest", 32'(want.became_earliest),
                          32'(got.became_earliest));
            compare_field("dropped_full", 32'(want.dropped_full), 32'(got.dropped_full));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        mode;
    logic [31:0] now_time;
    logic [23:0] delay;
    logic [31:0] subject_id;
    logic [31:0] target_id;
    logic [2:0]  event_kind;
    logic [15:0] zone_id;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        has_event;
    logic [31:0] out_subject;
    logic [31:0] out_target;
    logic [2:0]  out_kind;
    logic [15:0] out_zone;
    logic [31:0] out_wakeup;
    logic        last;
    logic        became_earliest;
    logic        dropped_full;

    event_queue_scoreboard sb;
    int          item_count;
    bit          no_idle;
    bit [31:0]   tick;

    timer_event_priority_queue #(.CAPACITY(CAPACITY)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .mode(mode),
        .now_time(now_time),
        .delay(delay),
        .subject_id(subject_id),
        .target_id(target_id),
        .event_kind(event_kind),
        .zone_id(zone_id),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .has_event(has_event),
        .out_subject(out_subject),
        .out_target(out_target),
        .out_kind(out_kind),
        .out_zone(out_zone),
        .out_wakeup(out_wakeup),
        .last(last),
        .became_earliest(became_earliest),
        .dropped_full(dropped_full)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
    end

    always #6 clk = ~clk;

    // Entered just after a falling edge; returns just after the falling edge that follows
    // acceptance, so valid is either held for the next transaction or lowered once.
    task automatic send_req(op_t op, bit [31:0] now, bit [23:0] dly, bit [31:0] subj,
                            bit [31:0] tgt, bit [2:0] kind, bit [15:0] zone);
        no_idle = (item_count >= 150 && item_count < 200);
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        mode       = op;
        now_time   = now;
        delay      = dly;
        subject_id = subj;
        target_id  = tgt;
        event_kind = kind;
        zone_id    = zone;
        req_valid  = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(op, now, dly, subj, tgt, kind, zone);
        item_count++;
        @(negedge clk);
    endtask

    task automatic schedule_near(bit [23:0] max_delay);
        send_req(OP_SCHEDULE, tick, 24'($urandom_range(0, max_delay)), $urandom, $urandom,
                 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    endtask

    // Fills the store past capacity so that the last schedules are dropped, then clears it.
    task automatic fill_and_flush();
        int extra;
        extra = CAPACITY + 2 - sb.occupancy();
        repeat (extra)
            schedule_near(24'd3000);
        send_req(OP_DRAIN, TIME_MAX, 24'($urandom), $urandom, $urandom,
                 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall = 1'b0;
        else
            rsp_stall = !no_idle && ($urandom_range(0, 99) < 38);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result({has_event, out_subject, out_target, out_kind, out_zone,
                             out_wakeup, last, became_earliest, dropped_full});
    end

    initial
    begin
        int pick;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        mode       = OP_SCHEDULE;
        now_time   = '0;
        delay      = '0;
        subject_id = '0;
        target_id  = '0;
        event_kind = '0;
        zone_id    = '0;
        item_count = 0;
        no_idle    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty drain, saturation, ties on wakeup and the earliest flag.
        send_req(OP_DRAIN, 32'd0, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_SCHEDULE, 32'd0, 24'd0, 32'hFFFF_FFFF, 32'd0, 3'd7, 16'hFFFF);
        send_req(OP_SCHEDULE, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0, 32'hFFFF_FFFF, 3'd0, 16'd0);
        send_req(OP_SCHEDULE, 32'hFF00_0000, 24'hFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
                 3'd5, 16'h5A5A);
        send_req(OP_SCHEDULE, 32'd100, 24'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 3'd2, 16'h0F0F);
        send_req(OP_SCHEDULE, 32'd0, 24'd0, 32'h0000_0001, 32'h8000_0000, 3'd4, 16'h8000);
        send_req(OP_SCHEDULE, 32'd50, 24'd10, 32'h8000_0000, 32'h0000_0001, 3'd1, 16'h0001);
        send_req(OP_DRAIN, 32'd60, 24'hFF_FFFF, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_DRAIN, 32'd60, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_DRAIN, 32'hFFFF_FFFE, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_DRAIN, 32'hFFFF_FFFF, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_SCHEDULE, 32'd1000, 24'd500, 32'd11, 32'd0, 3'd3, 16'd7);
        send_req(OP_SCHEDULE, 32'd1000, 24'd100, 32'd12, 32'd0, 3'd6, 16'd8);
        send_req(OP_DRAIN, 32'd1200, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);
        send_req(OP_DRAIN, 32'd1500, 24'd0, 32'd0, 32'd0, 3'd0, 16'd0);

        tick = $urandom_range(0, 1000);
        fill_and_flush();

        // Mostly schedules and drains on an advancing clock, with some wild values.
        while (item_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            tick = tick + $urandom_range(0, 40);
            if (pick < 58)
                schedule_near(24'd150);
            else if (pick < 84)
                send_req(OP_DRAIN, tick, 24'($urandom), $urandom, $urandom,
                         3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
            else if (pick < 92)
                send_req(OP_SCHEDULE, $urandom, 24'($urandom), $urandom, $urandom,
                         3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
            else if (pick < 97)
                send_req(OP_DRAIN, $urandom, 24'($urandom), $urandom, $urandom,
                         3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
            else
                fill_and_flush();
        end
        req_valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #24_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> timer_event_priority_queue.f
design/tepq_pkg.sv
design/tepq_slot_ram.sv
design/tepq_scan_unit.sv
design/timer_event_priority_queue.sv
test/timer_event_priority_queue_tb.sv
